>>> hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY    = 16;
  localparam int COORD_WIDTH = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OCC_W       = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [CNT_W-1:0]              count_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the input item, restart the scan
    logic scan_inc;  // advance the scan pointer
    logic exec;      // apply the operation and load the result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ins_go;    // captured item is an insert and there is room
    logic scan_hit;  // scan pointer sits at the insert position
  } dp_sts_t;

endpackage

>>> hw/rtl/spq_in_if.sv
interface spq_in_if;
  import spq_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, output kind, output point_x, output point_y, input ready);
  modport sink   (input valid, input kind, input point_x, input point_y, output ready);
endinterface

>>> hw/rtl/spq_out_if.sv
interface spq_out_if;
  import spq_pkg::*;

  logic             valid;
  logic             ready;
  coord_t           front_x;
  coord_t           front_y;
  logic [OCC_W-1:0] occupancy;
  logic             is_empty;
  logic [1:0]       status;

  modport source (output valid, output front_x, output front_y, output occupancy,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input front_x, input front_y, input occupancy,
                  input is_empty, input status, output ready);
endinterface

>>> hw/rtl/sorted_priority_queue_top.sv
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   kind, point_x, point_y
// out_ch   out  valid/ready   front_x, front_y, occupancy, is_empty, status
// cfg      in   cfg_we        cfg_wdata (order_by_y)
//
// An item is captured, scanned and then executed; an insert finds its position
// p in the one-entry-per-cycle key scan, while a remove or a flagged item does not advance it.
// One item is in work at a time; the scan through the entry row sets the rate while out_ready is high.
// Reset (rst_n low, synchronous) empties the queue and selects x ordering.
// A result waits in the output register while out_ready is low; the next
// item is still taken and held back only at its execute step.
module sorted_priority_queue_top (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import spq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequence capture, scan and execute; own the output handshake
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold the sorted entry row, the count, the order bit and the result
  spq_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_kind       (in_ch.kind),
    .in_point_x    (in_ch.point_x),
    .in_point_y    (in_ch.point_y),
    .cmd           (cmd),
    .sts           (sts),
    .out_front_x   (out_ch.front_x),
    .out_front_y   (out_ch.front_y),
    .out_occupancy (out_ch.occupancy),
    .out_is_empty  (out_ch.is_empty),
    .out_status    (out_ch.status)
  );

endmodule

>>> hw/rtl/spq_datapath.sv
module spq_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_kind,
  input  spq_pkg::coord_t               in_point_x,
  input  spq_pkg::coord_t               in_point_y,
  input  spq_pkg::dp_cmd_t              cmd,
  output spq_pkg::dp_sts_t              sts,
  output spq_pkg::coord_t               out_front_x,
  output spq_pkg::coord_t               out_front_y,
  output logic [spq_pkg::OCC_W-1:0]     out_occupancy,
  output logic                          out_is_empty,
  output logic [1:0]                    out_status
);
  import spq_pkg::*;

  coord_t ent_x_r [CAPACITY];
  coord_t ent_y_r [CAPACITY];
  coord_t ent_x_nxt [CAPACITY];
  coord_t ent_y_nxt [CAPACITY];

  count_t count_r, count_nxt;
  count_t idx_r;
  logic   order_r;
  logic   kind_r;
  coord_t px_r, py_r;

  coord_t           front_x_r, front_y_r;
  logic [OCC_W-1:0] occ_r;
  logic             empty_r;
  status_t          status_r, status_nxt;

  coord_t new_key, held_key;
  logic   full, empty, ins_ok, rem_ok;

  assign full   = (count_r == count_t'(CAPACITY));
  assign empty  = (count_r == '0);
  assign ins_ok = (kind_r == KIND_INSERT) && !full;
  assign rem_ok = (kind_r == KIND_REMOVE) && !empty;

  assign new_key  = order_r ? py_r : px_r;
  assign held_key = order_r ? ent_y_r[idx_r[IDX_W-1:0]] : ent_x_r[idx_r[IDX_W-1:0]];

  assign sts.ins_go   = ins_ok;
  assign sts.scan_hit = (idx_r == count_r) || (new_key < held_key);

  // per-entry shift cells: up on insert past the position, down on remove
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    coord_t up_x, up_y, dn_x, dn_y;
    if (i == 0) begin : g_first
      assign up_x = px_r;
      assign up_y = py_r;
    end else begin : g_rest
      assign up_x = ent_x_r[i-1];
      assign up_y = ent_y_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign dn_x = ent_x_r[i];
      assign dn_y = ent_y_r[i];
    end else begin : g_mid
      assign dn_x = ent_x_r[i+1];
      assign dn_y = ent_y_r[i+1];
    end

    always_comb begin
      ent_x_nxt[i] = ent_x_r[i];
      ent_y_nxt[i] = ent_y_r[i];
      if (ins_ok) begin
        if (count_t'(i) == idx_r) begin
          ent_x_nxt[i] = px_r;
          ent_y_nxt[i] = py_r;
        end else if (count_t'(i) > idx_r) begin
          ent_x_nxt[i] = up_x;
          ent_y_nxt[i] = up_y;
        end
      end else if (rem_ok) begin
        ent_x_nxt[i] = dn_x;
        ent_y_nxt[i] = dn_y;
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    if (kind_r == KIND_INSERT) begin
      if (full) status_nxt = ST_FULL;
      else      count_nxt  = count_r + count_t'(1);
    end else begin
      if (empty) status_nxt = ST_EMPTY;
      else       count_nxt  = count_r - count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      order_r <= 1'b0;
    end else begin
      if (cfg_we)   order_r <= cfg_wdata;
      if (cmd.exec) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      px_r   <= in_point_x;
      py_r   <= in_point_y;
      idx_r  <= '0;
    end else if (cmd.scan_inc) begin
      idx_r  <= idx_r + count_t'(1);
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        ent_x_r[i] <= ent_x_nxt[i];
        ent_y_r[i] <= ent_y_nxt[i];
      end
      front_x_r <= (count_nxt != '0) ? ent_x_nxt[0] : '0;
      front_y_r <= (count_nxt != '0) ? ent_y_nxt[0] : '0;
      occ_r     <= OCC_W'(count_nxt);
      empty_r   <= (count_nxt == '0);
      status_r  <= status_nxt;
    end
  end

  assign out_front_x   = front_x_r;
  assign out_front_y   = front_y_r;
  assign out_occupancy = occ_r;
  assign out_is_empty  = empty_r;
  assign out_status    = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= count_t'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && ins_ok |=> count_r == $past(count_r) + count_t'(1))
    else $error("insert did not grow the count");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && rem_ok |=> count_r == $past(count_r) - count_t'(1))
    else $error("remove did not shrink the count");

endmodule

>>> hw/rtl/spq_ctrl.sv
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  spq_pkg::dp_sts_t  sts,
  output spq_pkg::dp_cmd_t  cmd
);
  import spq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.ins_go || sts.scan_hit) state_nxt    = S_EXEC;
        else                             cmd.scan_inc = 1'b1;
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_exec_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("result not presented after execute");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> slot_free)
    else $error("result overwritten before transfer");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.scan_inc, cmd.exec}))
    else $error("conflicting datapath commands");

endmodule
